/* rtl/core/ewfr_pkg.sv */
// Shared types and constants for the excess water-filling redistributor.
// Used by the controller, the datapath and the top level.
package ewfr_pkg;

    localparam int MAX_SLOTS_DEF = 32;
    localparam int LVL_W         = 40;
    localparam int EXC_W         = 46;
    localparam int TOL_W         = 8;
    localparam int SLOT_W        = 5;
    localparam int DIV_STEPS     = 46;
    localparam int DCNT_W        = 6;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_EXCESS,
        OP_COUNT,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_SHARE,
        OP_APPLY,
        OP_ROUND_END,
        OP_EMIT
    } op_t;

    typedef struct packed {
        logic close_now;
        logic scan_last;
        logic np_zero;
        logic div_done;
        logic round_stop;
        logic out_free;
    } sts_t;

endpackage

/* rtl/core/excess_water_filling_redistributor_top.sv */
// Top level of the excess water-filling redistributor.
// Depends on ewfr_pkg, ewfr_ctrl and ewfr_dp.
//
// Usage: slots of one period enter on the input channel (in_valid/in_stall),
// one transaction per cycle while loading. A slot with last_slot set, or the
// slot that fills all MAX_SLOTS entries, closes the period; the input then
// stalls while the excess is summed and spread over the slots with headroom.
// Results leave on the output channel (out_valid/out_stall), one per slot in
// slot order, the final one with last_result set.
// Sequence for a period of n slots: the slots are loaded, the excess scan
// runs, then each round runs two slot scans and a 46-step serial divider,
// for at most n + 1 rounds, and then the results are emitted, one per slot.
// The tolerance register is to be written through cfg_valid/cfg_ready only
// while idle; the block does not enforce this. cfg_ready is always high.
// Reset clears the control state and the tolerance; slot memories keep
// undefined contents until loaded. A stalled result holds its output
// register, and the block waits until it is taken.
module excess_water_filling_redistributor_top
    import ewfr_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [LVL_W-1:0]  planned_level,
    input  logic [LVL_W-1:0]  ceiling_level,
    input  logic [LVL_W-1:0]  target_level,
    input  logic              last_slot,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [SLOT_W-1:0] slot_index,
    output logic [LVL_W-1:0]  adjusted_level,
    output logic              last_result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [TOL_W-1:0]  cfg_data
);

    op_t  op;
    sts_t sts;

    ewfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .op       (op),
        .in_stall (in_stall)
    );

    ewfr_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .sts            (sts),
        .planned_level  (planned_level),
        .ceiling_level  (ceiling_level),
        .target_level   (target_level),
        .last_slot      (last_slot),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .slot_index     (slot_index),
        .adjusted_level (adjusted_level),
        .last_result    (last_result),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

endmodule

/* rtl/core/ewfr_ctrl.sv */
// Sequencing state machine of the redistributor.
// Depends on ewfr_pkg for the operation codes and the status struct.
module ewfr_ctrl
    import ewfr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  sts_t sts,
    output op_t  op,
    output logic in_stall
);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_EX_ADDR,
        ST_EX_USE,
        ST_CNT_ADDR,
        ST_CNT_USE,
        ST_DIV_CHK,
        ST_DIV_RUN,
        ST_SHARE,
        ST_AP_ADDR,
        ST_AP_USE,
        ST_RND_END,
        ST_OUT_ADDR,
        ST_OUT_USE
    } state_t;

    state_t state_reg, state_next;
    logic   in_stall_reg;

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    op = OP_LOAD;
                    if (sts.close_now)
                        state_next = ST_EX_ADDR;
                end
            end
            ST_EX_ADDR:  state_next = ST_EX_USE;
            ST_EX_USE:
            begin
                op         = OP_EXCESS;
                state_next = sts.scan_last ? ST_CNT_ADDR : ST_EX_ADDR;
            end
            ST_CNT_ADDR: state_next = ST_CNT_USE;
            ST_CNT_USE:
            begin
                op         = OP_COUNT;
                state_next = sts.scan_last ? ST_DIV_CHK : ST_CNT_ADDR;
            end
            ST_DIV_CHK:
            begin
                if (sts.np_zero)
                    state_next = ST_OUT_ADDR;
                else
                begin
                    op         = OP_DIV_START;
                    state_next = ST_DIV_RUN;
                end
            end
            ST_DIV_RUN:
            begin
                op = OP_DIV_STEP;
                if (sts.div_done)
                    state_next = ST_SHARE;
            end
            ST_SHARE:
            begin
                op         = OP_SHARE;
                state_next = ST_AP_ADDR;
            end
            ST_AP_ADDR:  state_next = ST_AP_USE;
            ST_AP_USE:
            begin
                op         = OP_APPLY;
                state_next = sts.scan_last ? ST_RND_END : ST_AP_ADDR;
            end
            ST_RND_END:
            begin
                op         = OP_ROUND_END;
                state_next = sts.round_stop ? ST_OUT_ADDR : ST_CNT_ADDR;
            end
            ST_OUT_ADDR: state_next = ST_OUT_USE;
            ST_OUT_USE:
            begin
                if (sts.out_free)
                begin
                    op         = OP_EMIT;
                    state_next = sts.scan_last ? ST_LOAD : ST_OUT_ADDR;
                end
            end
            default:     state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= (state_next != ST_LOAD);
        end
    end

    assign in_stall = in_stall_reg;

    a_stall_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (state_reg != ST_LOAD))
        else $error("input stall out of step with the load state");

    a_load_only_when_open: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_LOAD) |-> !in_stall)
        else $error("slot written while the input is stalled");

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_EMIT) |-> sts.out_free)
        else $error("result loaded over an untaken result");

endmodule

/* rtl/core/ewfr_dp.sv */
// Datapath of the redistributor: slot memories, open flags, accumulators,
// the serial divider and the output register. Depends on ewfr_pkg.
module ewfr_dp
    import ewfr_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  op_t               op,
    output sts_t              sts,
    input  logic [LVL_W-1:0]  planned_level,
    input  logic [LVL_W-1:0]  ceiling_level,
    input  logic [LVL_W-1:0]  target_level,
    input  logic              last_slot,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [SLOT_W-1:0] slot_index,
    output logic [LVL_W-1:0]  adjusted_level,
    output logic              last_result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [TOL_W-1:0]  cfg_data
);

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    logic [LVL_W-1:0] level_mem   [MAX_SLOTS];
    logic [LVL_W-1:0] ceiling_mem [MAX_SLOTS];
    logic [LVL_W-1:0] target_mem  [MAX_SLOTS];
    logic [LVL_W-1:0] lvl_rd_reg, ceil_rd_reg, tgt_rd_reg;

    logic [MAX_SLOTS-1:0] open_reg;
    logic [IDX_W-1:0]     scan_idx_reg;
    logic [CNT_W-1:0]     slot_count_reg, n_reg, np_reg, div_rem_reg;
    logic [CNT_W:0]       round_reg, round_inc;
    logic [EXC_W-1:0]     remaining_reg, quot_reg;
    logic [LVL_W-1:0]     minh_reg, share_reg;
    logic [DCNT_W-1:0]    div_cnt_reg;
    logic                 hit_reg;
    logic [TOL_W-1:0]     tol_reg;

    logic                 out_valid_reg, last_result_reg;
    logic [SLOT_W-1:0]    slot_index_reg;
    logic [LVL_W-1:0]     adjusted_reg;

    logic [LVL_W:0]       diff_pt, diff_ct, lvl_sum, sat_diff;
    logic                 has_exc, has_room, saturates, cur_open, scan_last;
    logic [CNT_W:0]       div_trial, div_diff;
    logic                 div_bit;
    logic [IDX_W-1:0]     wr_addr;
    logic                 load_fire;

    assign diff_pt  = {1'b0, lvl_rd_reg} - {1'b0, tgt_rd_reg};
    assign diff_ct  = {1'b0, ceil_rd_reg} - {1'b0, tgt_rd_reg};
    assign has_exc  = !diff_pt[LVL_W] && (diff_pt[LVL_W-1:0] > LVL_W'(tol_reg));
    assign has_room = !diff_ct[LVL_W] && (diff_ct[LVL_W-1:0] > LVL_W'(tol_reg));
    // The share never exceeds the smallest headroom, so the level stays at or below its ceiling.
    assign lvl_sum   = {1'b0, tgt_rd_reg} + {1'b0, share_reg};
    assign sat_diff  = {1'b0, ceil_rd_reg} - lvl_sum;
    assign saturates = sat_diff <= (LVL_W+1)'(tol_reg);
    assign cur_open  = open_reg[scan_idx_reg];
    assign scan_last = scan_idx_reg == IDX_W'(n_reg - CNT_W'(1));

    assign div_trial = {div_rem_reg, quot_reg[EXC_W-1]};
    assign div_diff  = div_trial - {1'b0, np_reg};
    assign div_bit   = div_trial >= {1'b0, np_reg};
    assign round_inc = round_reg + (CNT_W+1)'(1);

    assign load_fire = op == OP_LOAD;
    assign wr_addr   = load_fire ? IDX_W'(slot_count_reg) : scan_idx_reg;

    assign sts.close_now  = last_slot || (slot_count_reg == CNT_W'(MAX_SLOTS - 1));
    assign sts.scan_last  = scan_last;
    assign sts.np_zero    = np_reg == '0;
    assign sts.div_done   = div_cnt_reg == DCNT_W'(1);
    assign sts.round_stop = !(hit_reg && (remaining_reg != '0)) ||
                            (round_inc > {1'b0, n_reg});
    assign sts.out_free   = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            ceiling_mem[wr_addr] <= ceiling_level;
            target_mem[wr_addr]  <= target_level;
        end
        if (load_fire)
            level_mem[wr_addr] <= planned_level;
        else if (op == OP_APPLY && cur_open)
            level_mem[wr_addr] <= lvl_sum[LVL_W-1:0];
        lvl_rd_reg  <= level_mem[scan_idx_reg];
        ceil_rd_reg <= ceiling_mem[scan_idx_reg];
        tgt_rd_reg  <= target_mem[scan_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_DIV_START: quot_reg <= remaining_reg;
            OP_DIV_STEP:  quot_reg <= {quot_reg[EXC_W-2:0], div_bit};
            default:      ;
        endcase
        if (op == OP_DIV_START)
            div_rem_reg <= '0;
        else if (op == OP_DIV_STEP)
            div_rem_reg <= div_bit ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
        if (op == OP_SHARE)
            share_reg <= (quot_reg < EXC_W'(minh_reg)) ? quot_reg[LVL_W-1:0] : minh_reg;
        if (op == OP_EMIT)
        begin
            slot_index_reg  <= SLOT_W'(scan_idx_reg);
            adjusted_reg    <= lvl_rd_reg;
            last_result_reg <= scan_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg       <= '0;
            scan_idx_reg   <= '0;
            slot_count_reg <= '0;
            n_reg          <= '0;
            np_reg         <= '0;
            round_reg      <= '0;
            remaining_reg  <= '0;
            minh_reg       <= '1;
            div_cnt_reg    <= '0;
            hit_reg        <= 1'b0;
            tol_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                tol_reg <= cfg_data;
            if (op == OP_EMIT)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (op)
                OP_LOAD:
                begin
                    scan_idx_reg <= '0;
                    if (sts.close_now)
                    begin
                        n_reg          <= slot_count_reg + CNT_W'(1);
                        slot_count_reg <= '0;
                        remaining_reg  <= '0;
                        round_reg      <= '0;
                    end
                    else
                        slot_count_reg <= slot_count_reg + CNT_W'(1);
                end
                OP_EXCESS:
                begin
                    if (has_exc)
                        remaining_reg <= remaining_reg + EXC_W'(diff_pt[LVL_W-1:0]);
                    open_reg[scan_idx_reg] <= has_room;
                    if (scan_last)
                    begin
                        np_reg   <= '0;
                        minh_reg <= '1;
                    end
                end
                OP_COUNT:
                begin
                    if (cur_open)
                    begin
                        np_reg <= np_reg + CNT_W'(1);
                        if (diff_ct[LVL_W-1:0] < minh_reg)
                            minh_reg <= diff_ct[LVL_W-1:0];
                    end
                end
                OP_DIV_START: div_cnt_reg <= DCNT_W'(DIV_STEPS);
                OP_DIV_STEP:  div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
                OP_SHARE:     hit_reg <= 1'b0;
                OP_APPLY:
                begin
                    if (cur_open && saturates)
                    begin
                        remaining_reg          <= remaining_reg - EXC_W'(share_reg);
                        hit_reg                <= 1'b1;
                        open_reg[scan_idx_reg] <= 1'b0;
                    end
                end
                OP_ROUND_END:
                begin
                    round_reg <= round_inc;
                    np_reg    <= '0;
                    minh_reg  <= '1;
                end
                default:      ;
            endcase
            if (op == OP_EXCESS || op == OP_COUNT || op == OP_APPLY || op == OP_EMIT)
                scan_idx_reg <= scan_last ? '0 : scan_idx_reg + IDX_W'(1);
        end
    end

    assign cfg_ready      = 1'b1;
    assign out_valid      = out_valid_reg;
    assign slot_index     = slot_index_reg;
    assign adjusted_level = adjusted_reg;
    assign last_result    = last_result_reg;

    a_np_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_DIV_START) |-> (np_reg <= n_reg))
        else $error("open slot count exceeds the period length");

    a_share_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_APPLY) |-> (share_reg <= minh_reg))
        else $error("share above the smallest headroom");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(op == OP_EMIT))
        else $error("result appeared without an emit");

endmodule

/* tb/tb.sv */
// Self-checking testbench for excess_water_filling_redistributor_top.
// Depends on ewfr_pkg and the RTL of the block.
// A scoreboard class predicts the redistributed levels.

class level_scoreboard;
    bit [39:0] plan_q[$];
    bit [39:0] ceil_q[$];
    bit [39:0] targ_q[$];
    bit [7:0] tol;
    bit [4:0] exp_idx[$];
    bit [39:0] exp_lvl[$];
    bit exp_last[$];
    int errors;

    function void note_slot(bit [39:0] p, bit [39:0] c, bit [39:0] t, bit last, int max_slots);
        plan_q.push_back(p);
        ceil_q.push_back(c);
        targ_q.push_back(t);
        if (last || plan_q.size() >= max_slots)
            spread_period();
    endfunction

    function void spread_period();
        int n;
        bit [45:0] rem;
        bit [39:0] lvl[$];
        bit opn[$];
        bit [63:0] np, minh, share, sum;
        bit hit, first;
        int rounds;
        n = plan_q.size();
        rem = 0;
        lvl = plan_q;
        for (int i = 0; i < n; i++)
        begin
            if (plan_q[i] > targ_q[i] && plan_q[i] - targ_q[i] > tol)
                rem += plan_q[i] - targ_q[i];
            opn.push_back(ceil_q[i] > targ_q[i] && ceil_q[i] - targ_q[i] > tol);
        end
        rounds = 0;
        forever
        begin
            np = 0;
            minh = 0;
            first = 1;
            hit = 0;
            for (int i = 0; i < n; i++)
            begin
                if (opn[i])
                begin
                    np++;
                    if (first || 64'(ceil_q[i] - targ_q[i]) < minh)
                        minh = ceil_q[i] - targ_q[i];
                    first = 0;
                end
            end
            if (np == 0)
                break;
            share = 64'(rem) / np;
            if (share > minh)
                share = minh;
            for (int i = 0; i < n; i++)
            begin
                if (opn[i])
                begin
                    sum = 64'(targ_q[i]) + share;
                    lvl[i] = sum[39:0];
                    if (64'(ceil_q[i]) - sum <= tol)
                    begin
                        rem -= share[45:0];
                        hit = 1;
                        opn[i] = 0;
                    end
                end
            end
            if (!(hit && rem > 0))
                break;
            rounds++;
            if (rounds > n)
                break;
        end
        for (int i = 0; i < n; i++)
        begin
            exp_idx.push_back(i[4:0]);
            exp_lvl.push_back(lvl[i]);
            exp_last.push_back(i == n - 1);
        end
        plan_q.delete();
        ceil_q.delete();
        targ_q.delete();
    endfunction

    function void check_level(bit [4:0] idx, bit [39:0] lvl, bit last);
        if (exp_idx.size() == 0)
        begin
            $display("%0t: unexpected result idx %0d level %0h", $time, idx, lvl);
            errors++;
            return;
        end
        if (idx !== exp_idx[0] || lvl !== exp_lvl[0] || last !== exp_last[0])
        begin
            $display("%0t: mismatch expected idx %0d level %0h last %0b,",
                     $time, exp_idx[0], exp_lvl[0], exp_last[0],
                     " actual idx %0d level %0h last %0b", idx, lvl, last);
            errors++;
        end
        void'(exp_idx.pop_front());
        void'(exp_lvl.pop_front());
        void'(exp_last.pop_front());
    endfunction
endclass

module tb
    import ewfr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 32;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic [LVL_W-1:0] planned_level = 0, ceiling_level = 0, target_level = 0;
    logic last_slot = 0;
    logic out_valid;
    logic out_stall = 0;
    logic [SLOT_W-1:0] slot_index;
    logic [LVL_W-1:0] adjusted_level;
    logic last_result;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [TOL_W-1:0] cfg_data = 0;

    level_scoreboard sb = new();
    int hold_cycles = 0;

    excess_water_filling_redistributor_top #(.MAX_SLOTS(NSLOT)) uut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic bit [39:0] rand_lvl();
        case ($urandom_range(0, 4))
            0: return 40'({$urandom, $urandom});
            1: return 40'($urandom_range(0, 2000));
            2: return 40'hFF_FFFF_FFFF - 40'($urandom_range(0, 300));
            default: return {8'h0, $urandom};
        endcase
    endfunction

    // Sends one slot transaction and records it with the scoreboard on acceptance.
    // Valid stays high after acceptance until the next gap or drain.
    task automatic send_slot(bit [39:0] p, bit [39:0] c, bit [39:0] t, bit last, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1;
        planned_level <= p;
        ceiling_level <= c;
        target_level <= t;
        last_slot <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_slot(p, c, t, last, NSLOT);
    endtask

    // A slot whose ceiling mostly sits a random amount above its target, else a random level.
    task automatic send_random_slot(bit last);
        bit [39:0] t, p, c;
        t = rand_lvl();
        p = ($urandom_range(0, 2) != 0) ? t + 40'($urandom_range(0, 100000)) : rand_lvl();
        c = ($urandom_range(0, 3) != 0) ? t + 40'($urandom_range(0, 100000)) : rand_lvl();
        send_slot(p, c, t, last, 1);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.exp_idx.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_tolerance(bit [7:0] v);
        cfg_valid <= 1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.tol = v;
        cfg_valid <= 0;
    endtask

    task automatic random_period(int len);
        for (int i = 0; i < len; i++)
            send_random_slot(i == len - 1);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_level(slot_index, adjusted_level, last_result);
        if (hold_cycles > 0)
        begin
            hold_cycles = hold_cycles - 1;
            out_stall <= 1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0;
        end
    end

    initial
    begin
        int sent;
        bit held;
        bit paused;
        held = 0;
        paused = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes and each special case.
        send_slot(40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 0, 1, 0);
        drain();
        send_slot(500, 2000, 100, 0, 0);
        send_slot(50, 40, 100, 0, 0);
        send_slot(100, 300, 100, 0, 0);
        send_slot(0, 0, 0, 1, 0);
        drain();
        send_slot(10, 5, 20, 0, 0);
        send_slot(90, 80, 80, 1, 0);
        drain();
        send_slot(40'hFF_FFFF_FFFF, 40'hAA_AAAA_AAAA, 40'h55_5555_5555, 0, 0);
        send_slot(40'h55_5555_5555, 40'hFF_FFFF_FFFF, 40'h00_0000_0001, 1, 0);
        drain();
        write_tolerance(8'hFF);
        send_slot(300, 1000, 100, 0, 0);
        send_slot(200, 355, 100, 0, 0);
        send_slot(100, 356, 100, 1, 0);
        drain();
        write_tolerance(8'h00);
        // A full store closes the period without last_slot.
        for (int i = 0; i < NSLOT; i++)
            send_slot(40'(1000 + i * 37), 40'(900 + i * 61), 800, 0, 0);
        drain();

        sent = 0;
        while (sent < 400)
        begin
            int len;
            if ($urandom_range(0, 7) == 0)
            begin
                drain();
                write_tolerance(($urandom_range(0, 2) == 0) ? 8'(($urandom_range(0, 1)) * 255)
                                                            : 8'($urandom));
            end
            len = ($urandom_range(0, 9) == 0) ? NSLOT : $urandom_range(1, 6);
            if (!held && sent > 150)
            begin
                hold_cycles = 300;
                held = 1;
            end
            if (!paused && sent > 250)
            begin
                drain();
                paused = 1;
            end
            random_period(len);
            sent += len;
        end
        drain();
        if (sb.errors == 0 && sb.exp_idx.size() == 0)
            $display("excess_water_filling_redistributor_top verification clean");
        else
            $display("excess_water_filling_redistributor_top verification failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("excess_water_filling_redistributor_top verification failed");
        $finish;
    end
endmodule

/* files.f */
rtl/core/ewfr_pkg.sv
rtl/core/ewfr_ctrl.sv
rtl/core/ewfr_dp.sv
rtl/core/excess_water_filling_redistributor_top.sv
tb/tb.sv
